[design/pidma_pkg.sv]
`timescale 1ns / 1ps
package pidma_pkg;

  // Fraction bits of the integral accumulator.
  localparam int INTEGRAL_FRAC_BITS = 16;
  localparam int K_SHIFT = INTEGRAL_FRAC_BITS - 8;

  localparam int IN_W = 24;
  localparam int GAIN_W = 16;
  localparam int DIFF_W = IN_W + 1;
  localparam int P_W = DIFF_W + GAIN_W;
  localparam int ACC_W = 48;
  localparam int DF_W = 40;
  localparam int DF_FRAC = 12;
  localparam int DNUM_W = 41;
  localparam int DM_W = DNUM_W + GAIN_W;
  localparam int DIV_W = P_W + K_SHIFT;
  localparam int V_W = P_W + 1;
  localparam int SUM_W = 49;
  localparam int WIDE_W = 80;
  localparam int DRIVE_W = 17;
  localparam int DRIVE_MAX = 100000;
  localparam int MANUAL_STEP = 100;
  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W = 8;

  localparam logic signed [WIDE_W-1:0] WIDE_MAX = (WIDE_W'(1) <<< (ACC_W - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = -(WIDE_W'(1) <<< (ACC_W - 1));

  typedef struct packed {
    logic signed [IN_W-1:0] setpoint;
    logic signed [IN_W-1:0] measured;
    logic signed [IN_W-1:0] track_value;
    logic                   auto_mode;
    logic                   step_up;
    logic                   step_down;
  } in_item_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               at_upper;
    logic               at_lower;
  } out_item_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN            = 8'd0,
    REG_INTEGRAL_TIME   = 8'd1,
    REG_DERIVATIVE_TIME = 8'd2,
    REG_CASCADE_MODE    = 8'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MUL_P,
    ST_LOAD_I,
    ST_DIV_I,
    ST_INT_SUM,
    ST_DIV_D,
    ST_D_POST,
    ST_MUL_D,
    ST_SUM,
    ST_CLAMP,
    ST_DONE
  } state_t;

  // Saturates a wide signed value to the accumulator width.
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] x);
    logic signed [ACC_W-1:0] res;
    if (x > WIDE_MAX) begin
      res = {1'b0, {(ACC_W-1){1'b1}}};
    end else if (x < WIDE_MIN) begin
      res = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      res = x[ACC_W-1:0];
    end
    return res;
  endfunction

endpackage

[design/pid_controller_manual_auto_core.sv]
`timescale 1ns / 1ps
// PID controller with manual/auto operation, anti-windup and bumpless transfer.
// One input beat on in_valid/in_ready is one sample tick; each tick gives exactly
// one output beat on out_valid/out_ready carrying the drive and the limit flags.
// Configuration beats (gain, integral time, derivative time, cascade mode) arrive
// on cfg_valid/cfg_ready, are always taken, and must only be sent while idle.
// A manual tick or a transfer tick goes from dispatch straight to the done
// state and the output register. An automatic tick runs through a bit-serial
// shift-add multiplier (for P and for D) and a restoring divider that retires
// one quotient bit a cycle (for the integral step and the derivative step);
// when derivative time is zero the D divide and multiply are skipped.
// One tick is processed at a time; in_ready is high only while the sequencer
// is idle, so no new tick is taken before the last one has left the
// sequencer. The finished result sits in an output register, so the next tick
// is accepted while the result still waits for out_ready.
// If the receiver stalls with a result still held, a newer finished result
// waits in the sequencer until the output register is free.
// Synchronous active-low reset loads the register defaults (gain 1.0, Ti 10,
// D off, no cascade), clears all controller state and empties the output
// register.
module pid_controller_manual_auto_core
  import pidma_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data
);

  // Configuration registers.
  logic [GAIN_W-1:0] gain_r;
  logic [GAIN_W-1:0] ti_r;
  logic [GAIN_W-1:0] td_r;
  logic              cascade_r;

  // Controller state.
  logic [DRIVE_W-1:0]      drive_r;
  logic                    hi_r;
  logic                    lo_r;
  logic signed [ACC_W-1:0] integ_r;
  logic signed [ACC_W-1:0] inew_r;
  logic signed [P_W-1:0]   lastp_r;
  logic signed [DF_W-1:0]  df_r;
  logic                    tracked_r;

  // Sequencer and datapath.
  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r;
  in_item_t                 item_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [P_W-1:0]    p_r;
  logic signed [DM_W-1:0]   mcand_r;
  logic [GAIN_W-1:0]        mplier_r;
  logic signed [DM_W-1:0]   macc_r;
  logic [GAIN_W-1:0]        drem_r;
  logic [DIV_W-1:0]         dquo_r;
  logic [GAIN_W-1:0]        dsor_r;
  logic                     dneg_r;
  logic [DNUM_W-1:0]        dabs_r;
  logic signed [SUM_W-1:0]  sum_r;
  out_item_t                out_r;
  logic                     out_valid_r;

  logic                     out_load;
  logic signed [DM_W-1:0]   macc_nxt;
  logic [GAIN_W:0]          div_trial;
  logic                     div_ge;
  logic [GAIN_W-1:0]        drem_nxt;
  logic [DIV_W-1:0]         dquo_nxt;
  logic signed [V_W-1:0]    casc_v;
  logic signed [ACC_W-1:0]  casc_integ;
  logic signed [ACC_W-1:0]  man_integ;
  out_item_t                casc_out;
  logic [P_W-1:0]           p_abs;
  logic [WIDE_W-1:0]        q_wide;
  logic signed [ACC_W-1:0]  inc_mag;
  logic signed [ACC_W-1:0]  inc_val;
  logic signed [ACC_W-1:0]  integ_sum;
  logic signed [DNUM_W-1:0] dnum;
  logic signed [DNUM_W-1:0] st_val;
  logic signed [DNUM_W-1:0] stdt_val;
  logic [DNUM_W-1:0]        stdt_mag;
  out_item_t                fin_out;
  logic [CNT_W-1:0]         mul_last;
  logic [CNT_W-1:0]         div_last;

  function automatic out_item_t clamp_drive(input logic signed [SUM_W-1:0] o);
    out_item_t r;
    r.at_upper = 1'b0;
    r.at_lower = 1'b0;
    if (o >= SUM_W'(DRIVE_MAX)) begin
      r.drive = DRIVE_W'(DRIVE_MAX);
      r.at_upper = 1'b1;
    end else if (o <= SUM_W'(0)) begin
      r.drive = '0;
      r.at_lower = 1'b1;
    end else begin
      r.drive = o[DRIVE_W-1:0];
    end
    return r;
  endfunction

  assign mul_last = CNT_W'(GAIN_W - 1);
  assign div_last = CNT_W'(DIV_W - 1);

  // Shift-add multiplier step and restoring divider step.
  always_comb begin
    macc_nxt = mplier_r[0] ? (macc_r + mcand_r) : macc_r;
    div_trial = {drem_r, dquo_r[DIV_W-1]};
    div_ge = (div_trial >= {1'b0, dsor_r});
    drem_nxt = div_ge ? GAIN_W'(div_trial - {1'b0, dsor_r}) : div_trial[GAIN_W-1:0];
    dquo_nxt = {dquo_r[DIV_W-2:0], div_ge};
  end

  // Transfer into automatic mode.
  always_comb begin
    casc_v = (V_W'($signed(item_r.track_value)) <<< 8) - V_W'(lastp_r);
    casc_integ = sat_acc(WIDE_W'(casc_v) <<< K_SHIFT);
    casc_out = clamp_drive(SUM_W'(casc_v >>> 8));
    man_integ = sat_acc(WIDE_W'($signed({1'b0, drive_r})) <<< INTEGRAL_FRAC_BITS);
  end

  // Integral increment, derivative numerator and final sum helpers.
  always_comb begin
    p_abs = macc_r[P_W-1] ? P_W'(-$signed(macc_r[P_W-1:0])) : macc_r[P_W-1:0];
    q_wide = WIDE_W'(dquo_r);
    if (q_wide >= (WIDE_W'(1) << (ACC_W - 1))) begin
      inc_mag = {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      inc_mag = q_wide[ACC_W-1:0];
    end
    inc_val = p_r[P_W-1] ? -inc_mag : inc_mag;
    integ_sum = sat_acc(WIDE_W'(integ_r) + WIDE_W'(inc_val));
    dnum = (DNUM_W'(diff_r) <<< DF_FRAC) - DNUM_W'(df_r);
    st_val = dneg_r ? -$signed(dquo_r[DNUM_W-1:0]) : $signed(dquo_r[DNUM_W-1:0]);
    stdt_mag = dabs_r - DNUM_W'(drem_r);
    stdt_val = dneg_r ? -$signed(stdt_mag) : $signed(stdt_mag);
    fin_out = clamp_drive(sum_r >>> 8);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_nxt = state_r;
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (item_r.auto_mode && tracked_r) begin
          state_nxt = ST_MUL_P;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_MUL_P: begin
        if (cnt_r == mul_last) begin
          state_nxt = ST_LOAD_I;
        end
      end
      ST_LOAD_I: state_nxt = ST_DIV_I;
      ST_DIV_I: begin
        if (cnt_r == div_last) begin
          state_nxt = ST_INT_SUM;
        end
      end
      ST_INT_SUM: begin
        if (td_r == '0) begin
          state_nxt = ST_SUM;
        end else begin
          state_nxt = ST_DIV_D;
        end
      end
      ST_DIV_D: begin
        if (cnt_r == div_last) begin
          state_nxt = ST_D_POST;
        end
      end
      ST_D_POST: state_nxt = ST_MUL_D;
      ST_MUL_D: begin
        if (cnt_r == mul_last) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_W'(256);
      ti_r <= GAIN_W'(10);
      td_r <= '0;
      cascade_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN:            gain_r <= cfg_data;
        REG_INTEGRAL_TIME:   ti_r <= cfg_data;
        REG_DERIVATIVE_TIME: td_r <= cfg_data;
        REG_CASCADE_MODE:    cascade_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Controller state, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r <= '0;
      hi_r <= 1'b0;
      lo_r <= 1'b0;
      integ_r <= '0;
      lastp_r <= '0;
      df_r <= '0;
      tracked_r <= 1'b0;
    end else begin
      case (state_r)
        ST_DISPATCH: begin
          hi_r <= 1'b0;
          lo_r <= 1'b0;
          if (!item_r.auto_mode) begin
            tracked_r <= 1'b0;
            if (item_r.step_up) begin
              if (drive_r >= DRIVE_W'(DRIVE_MAX - MANUAL_STEP)) begin
                drive_r <= DRIVE_W'(DRIVE_MAX);
              end else begin
                drive_r <= drive_r + DRIVE_W'(MANUAL_STEP);
              end
            end else if (item_r.step_down) begin
              if (drive_r <= DRIVE_W'(MANUAL_STEP)) begin
                drive_r <= '0;
              end else begin
                drive_r <= drive_r - DRIVE_W'(MANUAL_STEP);
              end
            end
          end else if (!tracked_r) begin
            if (cascade_r) begin
              integ_r <= casc_integ;
              drive_r <= casc_out.drive;
              hi_r <= casc_out.at_upper;
              lo_r <= casc_out.at_lower;
            end else begin
              integ_r <= man_integ;
            end
            df_r <= DF_W'(diff_r) <<< DF_FRAC;
            tracked_r <= 1'b1;
          end
        end
        ST_LOAD_I: lastp_r <= macc_r[P_W-1:0];
        ST_INT_SUM: begin
          if (td_r == '0) begin
            df_r <= '0;
          end
        end
        ST_D_POST: df_r <= df_r + DF_W'(st_val);
        ST_CLAMP: begin
          drive_r <= fin_out.drive;
          hi_r <= fin_out.at_upper;
          lo_r <= fin_out.at_lower;
          if (!fin_out.at_upper && !fin_out.at_lower) begin
            integ_r <= inew_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        item_r <= in_data;
        diff_r <= DIFF_W'(in_data.setpoint) - DIFF_W'(in_data.measured);
      end
      ST_DISPATCH: begin
        mcand_r <= DM_W'(diff_r);
        mplier_r <= gain_r;
        macc_r <= '0;
        cnt_r <= '0;
      end
      ST_MUL_P, ST_MUL_D: begin
        macc_r <= macc_nxt;
        mcand_r <= mcand_r <<< 1;
        mplier_r <= mplier_r >> 1;
        cnt_r <= cnt_r + CNT_W'(1);
      end
      ST_LOAD_I: begin
        p_r <= macc_r[P_W-1:0];
      end
      default: ;
    endcase
    // The integral divider takes |P| straight from the multiplier result.
    case (state_r)
      ST_LOAD_I: begin
        drem_r <= '0;
        dquo_r <= DIV_W'(p_abs) << K_SHIFT;
        dsor_r <= (ti_r == '0) ? GAIN_W'(1) : ti_r;
        cnt_r <= '0;
      end
      ST_DIV_I, ST_DIV_D: begin
        drem_r <= drem_nxt;
        dquo_r <= dquo_nxt;
        cnt_r <= cnt_r + CNT_W'(1);
      end
      ST_INT_SUM: begin
        inew_r <= integ_sum;
        macc_r <= '0;
        dneg_r <= dnum[DNUM_W-1];
        dabs_r <= dnum[DNUM_W-1] ? DNUM_W'(-dnum) : DNUM_W'(dnum);
        dquo_r <= DIV_W'(dnum[DNUM_W-1] ? DNUM_W'(-dnum) : DNUM_W'(dnum));
        drem_r <= '0;
        dsor_r <= td_r;
        cnt_r <= '0;
      end
      ST_D_POST: begin
        mcand_r <= DM_W'(stdt_val);
        mplier_r <= gain_r;
        macc_r <= '0;
        cnt_r <= '0;
      end
      ST_SUM: begin
        sum_r <= SUM_W'(p_r) + SUM_W'(inew_r >>> K_SHIFT) + SUM_W'(macc_r >>> DF_FRAC);
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.drive <= drive_r;
      out_r.at_upper <= hi_r;
      out_r.at_lower <= lo_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign cfg_ready = 1'b1;

`ifndef NO_ASSERTIONS
  // A new result appears only when the sequencer hands one over.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result appeared without a finished tick");

  // The drive never leaves its range.
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.drive <= DRIVE_W'(DRIVE_MAX))
    else $error("drive out of range");

  // Both limit flags never show together.
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.at_upper && out_r.at_lower))
    else $error("both limit flags set");

  // The derivative divide never runs with a zero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_D) |-> dsor_r != '0)
    else $error("zero divisor");
`endif

endmodule

[dv/pidma_checker.sv]
`timescale 1ns / 1ps
module pidma_checker
  import pidma_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   outstanding
);

  localparam longint ACC_HI = (64'sd1 <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;

  // Controller settings and state as the block should hold them.
  longint kp, ti_set, td_set;
  bit     cascade;
  longint drv, integ, prop_last, dfilt;
  bit     locked;

  out_item_t drive_queue[$];

  function automatic longint clip_acc(longint x);
    if (x > ACC_HI) return ACC_HI;
    if (x < ACC_LO) return ACC_LO;
    return x;
  endfunction

  function automatic longint scale_up_sat(longint x, int k);
    longint lim;
    lim = 64'sd1 <<< (ACC_W - 1 - k);
    if (x >= lim) return ACC_HI;
    if (x < -lim) return ACC_LO;
    return x <<< k;
  endfunction

  // Integral increment: P scaled to the accumulator format over Ti, toward zero.
  function automatic longint integral_step(longint p, longint t, int k);
    longint a, q, r, m;
    a = (p < 0) ? -p : p;
    q = a / t;
    r = a % t;
    if (q > (ACC_HI >>> k)) m = ACC_HI;
    else m = (q <<< k) + ((r <<< k) / t);
    return (p < 0) ? -m : m;
  endfunction

  function automatic out_item_t predict_tick(in_item_t it);
    out_item_t res;
    longint sp, mv, tv, diff, v, ti, prev, p, d, st, o;
    sp = longint'(it.setpoint);
    mv = longint'(it.measured);
    tv = longint'(it.track_value);
    diff = sp - mv;
    res.at_upper = 1'b0;
    res.at_lower = 1'b0;
    if (!it.auto_mode) begin
      locked = 0;
      if (it.step_up) begin
        drv = (drv >= DRIVE_MAX - MANUAL_STEP) ? DRIVE_MAX : drv + MANUAL_STEP;
      end else if (it.step_down) begin
        drv = (drv <= MANUAL_STEP) ? 0 : drv - MANUAL_STEP;
      end
    end else if (!locked) begin
      // Bumpless transfer into automatic.
      if (cascade) begin
        v = tv * 256 - prop_last;
        integ = scale_up_sat(v, K_SHIFT);
        drv = v >>> 8;
        if (drv >= DRIVE_MAX) begin
          drv = DRIVE_MAX;
          res.at_upper = 1'b1;
        end else if (drv <= 0) begin
          drv = 0;
          res.at_lower = 1'b1;
        end
      end else begin
        integ = scale_up_sat(drv, INTEGRAL_FRAC_BITS);
      end
      dfilt = diff <<< DF_FRAC;
      locked = 1;
    end else begin
      ti = (ti_set == 0) ? 1 : ti_set;
      prev = integ;
      p = diff * kp;
      prop_last = p;
      integ = clip_acc(prev + integral_step(p, ti, K_SHIFT));
      d = 0;
      if (td_set == 0) begin
        dfilt = 0;
      end else begin
        st = ((diff <<< DF_FRAC) - dfilt) / td_set;
        dfilt = dfilt + st;
        d = (st * td_set * kp) >>> DF_FRAC;
      end
      o = (p + (integ >>> K_SHIFT) + d) >>> 8;
      if (o >= DRIVE_MAX) begin
        drv = DRIVE_MAX;
        res.at_upper = 1'b1;
      end else if (o <= 0) begin
        drv = 0;
        res.at_lower = 1'b1;
      end else begin
        drv = o;
      end
      // Anti-windup: at a limit the integral does not move.
      if (res.at_upper || res.at_lower) integ = prev;
    end
    res.drive = drv[DRIVE_W-1:0];
    return res;
  endfunction

  assign outstanding = drive_queue.size();

  always @(posedge clk) begin
    out_item_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      kp = 256;
      ti_set = 10;
      td_set = 0;
      cascade = 0;
      drv = 0;
      integ = 0;
      prop_last = 0;
      dfilt = 0;
      locked = 0;
      drive_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_GAIN:            kp = cfg_data;
          REG_INTEGRAL_TIME:   ti_set = cfg_data;
          REG_DERIVATIVE_TIME: td_set = cfg_data;
          REG_CASCADE_MODE:    cascade = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) drive_queue.push_back(predict_tick(in_data));
      if (out_valid && out_ready) begin
        if (drive_queue.size() == 0) begin
          $error("result beat with no tick pending: drive %0d", out_data.drive);
          errs++;
        end else begin
          want = drive_queue.pop_front();
          if (want.drive !== out_data.drive) begin
            $error("drive: expected %0d, actual %0d", want.drive, out_data.drive);
            errs++;
          end
          if (want.at_upper !== out_data.at_upper) begin
            $error("at_upper: expected %0b, actual %0b", want.at_upper, out_data.at_upper);
            errs++;
          end
          if (want.at_lower !== out_data.at_lower) begin
            $error("at_lower: expected %0b, actual %0b", want.at_lower, out_data.at_lower);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

[dv/tb_pid_controller_manual_auto_core.sv]
`timescale 1ns / 1ps
module tb_pid_controller_manual_auto_core;
  import pidma_pkg::*;

  // Settling time long enough to cover any tick still in flight.
  localparam int SETTLE_CYCLES = 300;
  localparam int IDLE_LIMIT = 20000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0]    cfg_data = '0;

  int fail_count;
  int outstanding;
  bit long_hold = 0;
  bit in_auto = 0;
  int run_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pid_controller_manual_auto_core dut (.*);

  pidma_checker checker_i (.*);

  // Receiver: mostly random stalls, with stall-free stretches, and a long
  // hold-off when the stimulus asks for one so the block backs up its input.
  initial begin
    int stretch;
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end else begin
        stretch = $urandom_range(5, 60);
        if ($urandom_range(0, 2) == 0) begin
          out_ready <= 1'b1;
          repeat (stretch) @(posedge clk);
        end else begin
          repeat (stretch) begin
            out_ready <= ($urandom_range(0, 3) != 0);
            @(posedge clk);
          end
        end
      end
    end
  end

  // Watchdog: any cycle with no beat on any channel counts toward the limit.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_tick(input in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [GAIN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drain every expected result, then let any tick with no pending result finish.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input logic [15:0] g, input logic [15:0] ti,
                               input logic [15:0] td, input bit casc);
    drain();
    write_reg(REG_GAIN, g);
    write_reg(REG_INTEGRAL_TIME, ti);
    write_reg(REG_DERIVATIVE_TIME, td);
    write_reg(REG_CASCADE_MODE, {15'd0, casc});
  endtask

  function automatic in_item_t make_tick(int sp, int mv, int tv, bit am, bit up, bit dn);
    in_item_t it;
    it.setpoint = sp[IN_W-1:0];
    it.measured = mv[IN_W-1:0];
    it.track_value = tv[IN_W-1:0];
    it.auto_mode = am;
    it.step_up = up;
    it.step_down = dn;
    return it;
  endfunction

  // Process values: mostly inside the 0..100 percent span, sometimes anywhere
  // in the full 24-bit range so that every bit toggles.
  function automatic int pick_value();
    case ($urandom_range(0, 9))
      0: return 32'($signed($urandom_range(0, 24'hFFFFFF) << 8)) >>> 8;
      1: return ($urandom_range(0, 1) != 0) ? 8388607 : -8388608;
      default: return int'($urandom_range(0, 110000)) - 5000;
    endcase
  endfunction

  // Well-formed traffic is short manual runs followed by longer automatic runs.
  function automatic in_item_t random_tick();
    if (run_left == 0) begin
      in_auto = !in_auto;
      run_left = in_auto ? $urandom_range(4, 40) : $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) run_left = 1;
    end
    run_left--;
    return make_tick(pick_value(), pick_value(), pick_value(), in_auto,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  task automatic random_block(input int count);
    int gap;
    while (count > 0) begin
      repeat ($urandom_range(1, 12)) begin
        if (count > 0) begin
          send_tick(random_tick());
          count--;
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    in_item_t directed[$];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: manual buttons at the lower bound, hold, raise priority,
    // plain transfer, automatic ticks up into the upper limit and down to zero.
    directed.push_back(make_tick(0, 0, 0, 0, 0, 1));
    directed.push_back(make_tick(0, 0, 0, 0, 1, 1));
    directed.push_back(make_tick(0, 0, 0, 0, 1, 0));
    directed.push_back(make_tick(0, 0, 0, 0, 0, 0));
    directed.push_back(make_tick(50000, 40000, 0, 1, 0, 0));
    directed.push_back(make_tick(50000, 40000, 0, 1, 0, 0));
    directed.push_back(make_tick(8388607, -8388608, 0, 1, 0, 0));
    directed.push_back(make_tick(8388607, -8388608, 0, 1, 1, 1));
    directed.push_back(make_tick(-8388608, 8388607, 0, 1, 0, 0));
    directed.push_back(make_tick(-8388608, 8388607, 0, 1, 0, 0));
    foreach (directed[i]) send_tick(directed[i]);
    directed.delete();

    // Cascade transfer at both track extremes, with the derivative on and Ti zero.
    load_settings(16'hFFFF, 16'd0, 16'd1, 1'b1);
    directed.push_back(make_tick(0, 0, 8388607, 0, 0, 0));
    directed.push_back(make_tick(100, 0, 8388607, 1, 0, 0));
    directed.push_back(make_tick(100, 0, 0, 1, 0, 0));
    directed.push_back(make_tick(-100, 0, 0, 1, 0, 0));
    directed.push_back(make_tick(0, 0, 0, 0, 0, 0));
    directed.push_back(make_tick(0, 0, -8388608, 1, 0, 0));
    directed.push_back(make_tick(0, 0, 60000, 0, 0, 0));
    directed.push_back(make_tick(0, 0, 60000, 1, 0, 0));
    directed.push_back(make_tick(2000, 1000, 0, 1, 0, 0));
    foreach (directed[i]) send_tick(directed[i]);

    // Random phases across settings, extremes first.
    load_settings(16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    random_block(140);
    load_settings(16'd256, 16'd10, 16'd0, 1'b1);
    random_block(140);

    // Fill the block while the receiver holds off.
    long_hold = 1;
    random_block(40);
    drain();

    load_settings(16'hFFFF, 16'd1, 16'd5, 1'b0);
    random_block(140);
    repeat (4) begin
      load_settings(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                    16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
      random_block(80);
      load_settings(16'($urandom_range(16, 1024)), 16'($urandom_range(0, 50)),
                    16'($urandom_range(0, 30)), 1'($urandom_range(0, 1)));
      random_block(80);
    end

    drain();
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[pid_controller_manual_auto_core.f]
design/pidma_pkg.sv
design/pid_controller_manual_auto_core.sv
dv/pidma_checker.sv
dv/tb_pid_controller_manual_auto_core.sv
